// File: sv/fcpk_pkg.sv
// Shared widths, register codes, pipeline word type and saturation helper.
package fcpk_pkg;

   localparam int FIELD_W = 22;   // every I/O length and position field
   localparam int REG_W   = 20;   // travel width / height registers
   localparam int DIFF_W  = 24;   // W +- 2x, H +- 2y
   localparam int MAG_W   = 23;   // magnitude of a DIFF_W value
   localparam int RAD_W   = 48;   // square root radicand
   localparam int ROOT_W  = RAD_W / 2;
   localparam int CAB_W   = 25;   // relative cable length before clamp
   localparam int LEN_W   = 23;   // absolute forward cable length
   localparam int ALEN_W  = 22;   // magnitude of a LEN_W value
   localparam int N_W     = 47;   // W^2 + a^2 - b^2, signed
   localparam int NUM_W   = 47;   // divider numerator
   localparam int DEN_W   = 21;   // divider denominator
   localparam int X2_W    = 48;   // signed doubled x from the divide
   localparam int SAT_W   = 49;   // common width ahead of the clamp

   localparam logic [REG_W-1:0] WIDTH_RESET  = 20'd140800;
   localparam logic [REG_W-1:0] HEIGHT_RESET = 20'd141312;

   localparam logic signed [SAT_W-1:0] FIELD_MAX = 49'sd2097151;
   localparam logic signed [SAT_W-1:0] FIELD_MIN = -49'sd2097152;

   typedef enum logic [0:0] {
      CSR_TRAVEL_WIDTH  = 1'b0,
      CSR_TRAVEL_HEIGHT = 1'b1
   } csr_index_type;

   typedef enum logic [0:0] {
      REQ_INVERSE = 1'b0,
      REQ_FORWARD = 1'b1
   } req_kind_type;

   // word that travels alongside the arithmetic units
   typedef struct packed {
      req_kind_type               kind;
      logic signed [FIELD_W-1:0]  tl;
      logic signed [FIELD_W-1:0]  tr;
      logic signed [CAB_W-1:0]    cab0;
      logic signed [CAB_W-1:0]    cab1;
      logic signed [CAB_W-1:0]    cab2;
      logic signed [CAB_W-1:0]    cab3;
      logic signed [LEN_W-1:0]    a;
      logic                       nsign;
      logic                       neg;
      logic [ROOT_W-1:0]          q24;
      logic signed [X2_W-1:0]     x2;
   } item_type;

   // {clamped flag, value}
   function automatic logic [FIELD_W:0] sat_field(input logic signed [SAT_W-1:0] v);
      logic [FIELD_W:0] r;
      if (v > FIELD_MAX) begin
         r = {1'b1, FIELD_MAX[FIELD_W-1:0]};
      end else if (v < FIELD_MIN) begin
         r = {1'b1, FIELD_MIN[FIELD_W-1:0]};
      end else begin
         r = {1'b0, v[FIELD_W-1:0]};
      end
      return r;
   endfunction

endpackage

// File: sv/fcpk_isqrt_pipe.sv
// Pipelined floor square root, one result bit per stage.
module fcpk_isqrt_pipe #(
   parameter int RAD_BITS = 48
) (
   input  logic                  clock,
   input  logic                  en,
   input  logic [RAD_BITS-1:0]   rad_in,
   output logic [RAD_BITS/2-1:0] root_out
);
   localparam int RB = RAD_BITS / 2;

   logic [RB:0]         rem_ff  [RB];
   logic [RB-1:0]       root_ff [RB];
   logic [RAD_BITS-1:0] rad_ff  [RB];

   for (genvar k = 0; k < RB; k++) begin : g_step
      logic [RB:0]         rem_cur;
      logic [RB-1:0]       root_cur;
      logic [RAD_BITS-1:0] rad_cur;
      logic [RB+2:0]       cand;
      logic [RB+2:0]       trial;
      logic [RB+2:0]       diff;
      logic                ge;

      if (k == 0) begin : g_first
         assign rem_cur  = '0;
         assign root_cur = '0;
         assign rad_cur  = rad_in;
      end else begin : g_next
         assign rem_cur  = rem_ff[k-1];
         assign root_cur = root_ff[k-1];
         assign rad_cur  = rad_ff[k-1];
      end

      assign cand  = {rem_cur, rad_cur[RAD_BITS-1 -: 2]};
      assign trial = {1'b0, root_cur, 2'b01};
      assign diff  = cand - trial;
      assign ge    = (cand >= trial);

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= ge ? diff[RB:0] : cand[RB:0];
            root_ff[k] <= {root_cur[RB-2:0], ge};
            rad_ff[k]  <= {rad_cur[RAD_BITS-3:0], 2'b00};
         end
      end
   end

   assign root_out = root_ff[RB-1];

endmodule

// File: sv/fcpk_div_pipe.sv
// Pipelined restoring unsigned divider, one quotient bit per stage.
module fcpk_div_pipe #(
   parameter int NUM_BITS = 47,
   parameter int DEN_BITS = 21
) (
   input  logic                clock,
   input  logic                en,
   input  logic [NUM_BITS-1:0] num_in,
   input  logic [DEN_BITS-1:0] den_in,
   output logic [NUM_BITS-1:0] quot_out
);
   logic [DEN_BITS-1:0] rem_ff [NUM_BITS];
   logic [NUM_BITS-1:0] nq_ff  [NUM_BITS];
   logic [DEN_BITS-1:0] den_ff [NUM_BITS];

   for (genvar k = 0; k < NUM_BITS; k++) begin : g_step
      logic [DEN_BITS-1:0] rem_cur;
      logic [NUM_BITS-1:0] nq_cur;
      logic [DEN_BITS-1:0] den_cur;
      logic [DEN_BITS:0]   cand;
      logic [DEN_BITS:0]   diff;
      logic                ge;

      if (k == 0) begin : g_first
         assign rem_cur = '0;
         assign nq_cur  = num_in;
         assign den_cur = den_in;
      end else begin : g_next
         assign rem_cur = rem_ff[k-1];
         assign nq_cur  = nq_ff[k-1];
         assign den_cur = den_ff[k-1];
      end

      assign cand = {rem_cur, nq_cur[NUM_BITS-1]};
      assign ge   = (cand >= {1'b0, den_cur});
      assign diff = cand - {1'b0, den_cur};

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= ge ? diff[DEN_BITS-1:0] : cand[DEN_BITS-1:0];
            nq_ff[k]  <= {nq_cur[NUM_BITS-2:0], ge};
            den_ff[k] <= den_cur;
         end
      end
   end

   assign quot_out = nq_ff[NUM_BITS-1];

endmodule

// File: sv/fcpk_delay.sv
// Stallable delay line with a valid lane, matches an arithmetic unit's latency.
module fcpk_delay #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             vld_in,
   input  logic [WIDTH-1:0] data_in,
   output logic             vld_out,
   output logic [WIDTH-1:0] data_out
);
   logic             vld_ff  [DEPTH];
   logic [WIDTH-1:0] data_ff [DEPTH];

   for (genvar k = 0; k < DEPTH; k++) begin : g_tap
      logic             vld_cur;
      logic [WIDTH-1:0] data_cur;
      if (k == 0) begin : g_first
         assign vld_cur  = vld_in;
         assign data_cur = data_in;
      end else begin : g_next
         assign vld_cur  = vld_ff[k-1];
         assign data_cur = data_ff[k-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            data_ff[k] <= data_cur;
         end
      end
   end

   assign vld_out  = vld_ff[DEPTH-1];
   assign data_out = data_ff[DEPTH-1];

endmodule

// File: sv/four_cable_plotter_kinematics.sv
// Four-cable plotter kinematics: pipelined inverse and forward solver.
//
// Request words (req_valid / req_stall) carry req_type and either a target
// point (inverse) or the relative top-left / top-right lengths (forward).
// Each request gives exactly one response word on rsp_valid / rsp_stall.
// csr_* writes travel_width (index 0) or travel_height (index 1); csr_ready
// is always high. Write the registers only while the pipe is empty.
// From the accepting edge to the edge that raises rsp_valid there are
// 105 register stages: 3 squaring stages, a 24-stage square
// root (base and four cables in parallel), 3 stages for the forward
// squares, a 47-stage divider, 3 stages for the radicand, a second
// 24-stage square root and the output register.
// Throughput is one word per clock while rsp_stall does not hold a word;
// every stage is fully pipelined. A stalled response freezes the whole
// pipe; a one-word skid at the input still takes the next request, and
// req_stall comes straight from that skid register.
// Reset (synchronous) empties the pipe and skid and reloads the travel
// registers with their defaults; no stored arithmetic needs clearing.
module four_cable_plotter_kinematics (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_type,
   input  logic signed [21:0]            req_target_x,
   input  logic signed [21:0]            req_target_y,
   input  logic signed [21:0]            req_top_left_len,
   input  logic signed [21:0]            req_top_right_len,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [21:0]            rsp_cable_top_left,
   output logic signed [21:0]            rsp_cable_top_right,
   output logic signed [21:0]            rsp_cable_bottom_right,
   output logic signed [21:0]            rsp_cable_bottom_left,
   output logic signed [21:0]            rsp_solved_x,
   output logic signed [21:0]            rsp_solved_y,
   output logic                          rsp_unreachable,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  fcpk_pkg::csr_index_type       csr_index,
   input  logic [19:0]                   csr_data
);
   import fcpk_pkg::*;

   localparam int ITEM_W = $bits(item_type);

   // ---------------- configuration registers ----------------
   logic [REG_W-1:0] width_ff, height_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_TRAVEL_WIDTH:  width_ff  <= csr_data;
            CSR_TRAVEL_HEIGHT: height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // whole pipe advances unless a finished word is held at the output
   logic adv;
   logic rsp_valid_ff;
   assign adv = !rsp_valid_ff || !rsp_stall;

   // ---------------- input skid ----------------
   logic                      skid_vld_ff, skid_vld_in;
   logic                      skid_type_ff;
   logic signed [FIELD_W-1:0] skid_x_ff, skid_y_ff, skid_tl_ff, skid_tr_ff;

   assign req_stall   = skid_vld_ff;
   assign skid_vld_in = skid_vld_ff ? !adv : (req_valid && !adv);

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_vld_ff <= 1'b0;
      end else begin
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!skid_vld_ff) begin
         skid_type_ff <= req_type;
         skid_x_ff    <= req_target_x;
         skid_y_ff    <= req_target_y;
         skid_tl_ff   <= req_top_left_len;
         skid_tr_ff   <= req_top_right_len;
      end
   end

   logic                      src_vld, src_type;
   logic signed [FIELD_W-1:0] src_x, src_y, src_tl, src_tr;

   assign src_vld  = skid_vld_ff || req_valid;
   assign src_type = skid_vld_ff ? skid_type_ff : req_type;
   assign src_x    = skid_vld_ff ? skid_x_ff    : req_target_x;
   assign src_y    = skid_vld_ff ? skid_y_ff    : req_target_y;
   assign src_tl   = skid_vld_ff ? skid_tl_ff   : req_top_left_len;
   assign src_tr   = skid_vld_ff ? skid_tr_ff   : req_top_right_len;

   // ---------------- S1: corner offsets ----------------
   logic                     v1_ff;
   item_type                 i1_ff, i1_in;
   logic signed [DIFF_W-1:0] dxa_ff, dxb_ff, dya_ff, dyb_ff;
   logic signed [DIFF_W-1:0] x2e, y2e, wz, hz;

   assign x2e = {src_x[FIELD_W-1], src_x, 1'b0};
   assign y2e = {src_y[FIELD_W-1], src_y, 1'b0};
   assign wz  = $signed({{(DIFF_W-REG_W){1'b0}}, width_ff});
   assign hz  = $signed({{(DIFF_W-REG_W){1'b0}}, height_ff});

   always_comb begin
      i1_in      = '0;
      i1_in.kind = req_kind_type'(src_type);
      i1_in.tl   = src_tl;
      i1_in.tr   = src_tr;
   end

   // a word caught by the skid only enters here once the pipe moves
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= src_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         i1_ff  <= i1_in;
         dxa_ff <= wz + x2e;
         dxb_ff <= wz - x2e;
         dya_ff <= hz - y2e;
         dyb_ff <= hz + y2e;
      end
   end

   // ---------------- S2: squares ----------------
   logic                    v2_ff;
   item_type                i2_ff;
   logic [2*MAG_W-1:0]      sq_xa_ff, sq_xb_ff, sq_ya_ff, sq_yb_ff;
   logic [2*REG_W-1:0]      sq_w_ff, sq_h_ff;
   logic signed [DIFF_W-1:0] nxa, nxb, nya, nyb;
   logic [MAG_W-1:0]        mxa, mxb, mya, myb;

   assign nxa = -dxa_ff;
   assign nxb = -dxb_ff;
   assign nya = -dya_ff;
   assign nyb = -dyb_ff;
   assign mxa = dxa_ff[DIFF_W-1] ? nxa[MAG_W-1:0] : dxa_ff[MAG_W-1:0];
   assign mxb = dxb_ff[DIFF_W-1] ? nxb[MAG_W-1:0] : dxb_ff[MAG_W-1:0];
   assign mya = dya_ff[DIFF_W-1] ? nya[MAG_W-1:0] : dya_ff[MAG_W-1:0];
   assign myb = dyb_ff[DIFF_W-1] ? nyb[MAG_W-1:0] : dyb_ff[MAG_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         i2_ff    <= i1_ff;
         sq_xa_ff <= mxa * mxa;
         sq_xb_ff <= mxb * mxb;
         sq_ya_ff <= mya * mya;
         sq_yb_ff <= myb * myb;
         sq_w_ff  <= width_ff * width_ff;
         sq_h_ff  <= height_ff * height_ff;
      end
   end

   // ---------------- S3: radicands ----------------
   // lanes 0..3 are the cables in output order, lane 4 is the origin length
   logic             v3_ff;
   item_type         i3_ff;
   logic [RAD_W-1:0] rad3_ff [5];

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (adv) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         i3_ff      <= i2_ff;
         rad3_ff[0] <= {2'b00, sq_xa_ff} + {2'b00, sq_ya_ff};
         rad3_ff[1] <= {2'b00, sq_xb_ff} + {2'b00, sq_ya_ff};
         rad3_ff[2] <= {2'b00, sq_xb_ff} + {2'b00, sq_yb_ff};
         rad3_ff[3] <= {2'b00, sq_xa_ff} + {2'b00, sq_yb_ff};
         rad3_ff[4] <= {{(RAD_W-2*REG_W){1'b0}}, sq_w_ff}
                     + {{(RAD_W-2*REG_W){1'b0}}, sq_h_ff};
      end
   end

   // ---------------- first square root ----------------
   logic [ROOT_W-1:0] root4 [5];

   for (genvar l = 0; l < 5; l++) begin : g_isq
      fcpk_isqrt_pipe #(.RAD_BITS(RAD_W)) u_isqrt (
         .clock    (clock),
         .en       (adv),
         .rad_in   (rad3_ff[l]),
         .root_out (root4[l])
      );
   end

   logic     v4;
   item_type i4;
   logic [ITEM_W-1:0] i4_bits;

   fcpk_delay #(.WIDTH(ITEM_W), .DEPTH(ROOT_W)) u_dly_isq (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .vld_in   (v3_ff),
      .data_in  (i3_ff),
      .vld_out  (v4),
      .data_out (i4_bits)
   );
   assign i4 = item_type'(i4_bits);

   // ---------------- C1: half lengths, cables, a and b ----------------
   logic [ROOT_W:0]          hm_sum [5];
   logic [ROOT_W-1:0]        hm     [5];
   logic signed [CAB_W-1:0]  cab    [4];
   logic signed [LEN_W-1:0]  base_l, a_in, b_in;
   item_type                 i5_in, i5_ff;
   logic                     v5_ff;
   logic signed [LEN_W-1:0]  b5_ff;

   for (genvar l = 0; l < 5; l++) begin : g_half
      assign hm_sum[l] = {1'b0, root4[l]} + {{ROOT_W{1'b0}}, 1'b1};
      assign hm[l]     = hm_sum[l][ROOT_W:1];
   end
   for (genvar l = 0; l < 4; l++) begin : g_cab
      assign cab[l] = $signed({1'b0, hm[l]}) - $signed({1'b0, hm[4]});
   end

   // origin length is below 2^20, so a 22-bit slice is exact
   assign base_l = $signed({1'b0, hm[4][ALEN_W-1:0]});
   assign a_in   = $signed({i4.tl[FIELD_W-1], i4.tl}) + base_l;
   assign b_in   = $signed({i4.tr[FIELD_W-1], i4.tr}) + base_l;

   always_comb begin
      i5_in      = i4;
      i5_in.cab0 = cab[0];
      i5_in.cab1 = cab[1];
      i5_in.cab2 = cab[2];
      i5_in.cab3 = cab[3];
      i5_in.a    = a_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (adv) begin
         v5_ff <= v4;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         i5_ff <= i5_in;
         b5_ff <= b_in;
      end
   end

   // ---------------- C2: forward squares ----------------
   logic                    v6_ff;
   item_type                i6_ff;
   logic [2*ALEN_W-1:0]     a2_ff, b2_ff;
   logic [2*REG_W-1:0]      w2_ff;
   logic signed [LEN_W-1:0] na5, nb5;
   logic [ALEN_W-1:0]       ma5, mb5;

   assign na5 = -i5_ff.a;
   assign nb5 = -b5_ff;
   assign ma5 = i5_ff.a[LEN_W-1] ? na5[ALEN_W-1:0] : i5_ff.a[ALEN_W-1:0];
   assign mb5 = b5_ff[LEN_W-1]   ? nb5[ALEN_W-1:0] : b5_ff[ALEN_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else if (adv) begin
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         i6_ff <= i5_ff;
         a2_ff <= ma5 * ma5;
         b2_ff <= mb5 * mb5;
         w2_ff <= width_ff * width_ff;
      end
   end

   // ---------------- C3: rounded-divide operands ----------------
   // X2 = round(N / W) with ties away from zero: (2|N| + W) / (2W)
   logic                  v7_ff;
   item_type              i7_ff, i7_in;
   logic [NUM_W-1:0]      num7_ff;
   logic [DEN_W-1:0]      den7_ff;
   logic signed [N_W-1:0] n_val, n_neg;
   logic [N_W-2:0]        n_mag;
   logic [REG_W-1:0]      div_w;

   assign n_val = $signed({{(N_W-2*REG_W){1'b0}}, w2_ff})
                + $signed({{(N_W-2*ALEN_W){1'b0}}, a2_ff})
                - $signed({{(N_W-2*ALEN_W){1'b0}}, b2_ff});
   assign n_neg = -n_val;
   assign n_mag = n_val[N_W-1] ? n_neg[N_W-2:0] : n_val[N_W-2:0];
   // zero width divides by one
   assign div_w = (width_ff == '0) ? {{(REG_W-1){1'b0}}, 1'b1} : width_ff;

   always_comb begin
      i7_in       = i6_ff;
      i7_in.nsign = n_val[N_W-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v7_ff <= 1'b0;
      end else if (adv) begin
         v7_ff <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         i7_ff   <= i7_in;
         num7_ff <= {n_mag, 1'b0} + {{(NUM_W-REG_W){1'b0}}, div_w};
         den7_ff <= {div_w, 1'b0};
      end
   end

   // ---------------- divider ----------------
   logic [NUM_W-1:0]  quot8;
   logic              v8;
   item_type          i8;
   logic [ITEM_W-1:0] i8_bits;

   fcpk_div_pipe #(.NUM_BITS(NUM_W), .DEN_BITS(DEN_W)) u_div (
      .clock    (clock),
      .en       (adv),
      .num_in   (num7_ff),
      .den_in   (den7_ff),
      .quot_out (quot8)
   );

   fcpk_delay #(.WIDTH(ITEM_W), .DEPTH(NUM_W)) u_dly_div (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .vld_in   (v7_ff),
      .data_in  (i7_ff),
      .vld_out  (v8),
      .data_out (i8_bits)
   );
   assign i8 = item_type'(i8_bits);

   // ---------------- E1: sign, range check ----------------
   logic                    v9_ff;
   item_type                i9_ff, i9_in;
   logic signed [LEN_W-1:0] na8;
   logic [ALEN_W-1:0]       ma8;
   logic signed [X2_W-1:0]  q_s;

   assign na8 = -i8.a;
   assign ma8 = i8.a[LEN_W-1] ? na8[ALEN_W-1:0] : i8.a[ALEN_W-1:0];
   assign q_s = $signed({1'b0, quot8});

   always_comb begin
      i9_in     = i8;
      // circle radius 2|a| smaller than |X2|: no real y
      i9_in.neg = (quot8 > {{(NUM_W-ALEN_W-1){1'b0}}, ma8, 1'b0});
      i9_in.x2  = i8.nsign ? -q_s : q_s;
      i9_in.q24 = quot8[ROOT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v9_ff <= 1'b0;
      end else if (adv) begin
         v9_ff <= v8;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         i9_ff <= i9_in;
      end
   end

   // ---------------- E2: X2^2 and a^2 ----------------
   logic                    v10_ff;
   item_type                i10_ff;
   logic [2*ROOT_W-1:0]     qsq10_ff;
   logic [2*ALEN_W-1:0]     asq10_ff;
   logic signed [LEN_W-1:0] na9;
   logic [ALEN_W-1:0]       ma9;

   assign na9 = -i9_ff.a;
   assign ma9 = i9_ff.a[LEN_W-1] ? na9[ALEN_W-1:0] : i9_ff.a[ALEN_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v10_ff <= 1'b0;
      end else if (adv) begin
         v10_ff <= v9_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         i10_ff   <= i9_ff;
         qsq10_ff <= i9_ff.q24 * i9_ff.q24;
         asq10_ff <= ma9 * ma9;
      end
   end

   // ---------------- E3: y radicand ----------------
   logic             v11_ff;
   item_type         i11_ff;
   logic [RAD_W-1:0] rad11_ff;
   logic [RAD_W-1:0] a4_ext;

   assign a4_ext = {{(RAD_W-2*ALEN_W-2){1'b0}}, asq10_ff, 2'b00};

   always_ff @(posedge clock) begin
      if (reset) begin
         v11_ff <= 1'b0;
      end else if (adv) begin
         v11_ff <= v10_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         i11_ff   <= i10_ff;
         rad11_ff <= i10_ff.neg ? '0 : (a4_ext - qsq10_ff);
      end
   end

   // ---------------- second square root ----------------
   logic [ROOT_W-1:0] y2_root;
   logic              v12;
   item_type          i12;
   logic [ITEM_W-1:0] i12_bits;

   fcpk_isqrt_pipe #(.RAD_BITS(RAD_W)) u_isqrt_y (
      .clock    (clock),
      .en       (adv),
      .rad_in   (rad11_ff),
      .root_out (y2_root)
   );

   fcpk_delay #(.WIDTH(ITEM_W), .DEPTH(ROOT_W)) u_dly_y (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .vld_in   (v11_ff),
      .data_in  (i11_ff),
      .vld_out  (v12),
      .data_out (i12_bits)
   );
   assign i12 = item_type'(i12_bits);

   // ---------------- G: clamp and output register ----------------
   logic signed [SAT_W-1:0] sx_full, sy_full;
   logic [FIELD_W:0]        s_c0, s_c1, s_c2, s_c3, s_x, s_y;

   assign sx_full = ($signed({i12.x2[X2_W-1], i12.x2})
                   - $signed({{(SAT_W-REG_W){1'b0}}, width_ff})
                   + 49'sd1) >>> 1;
   assign sy_full = ($signed({{(SAT_W-REG_W){1'b0}}, height_ff})
                   - $signed({{(SAT_W-ROOT_W){1'b0}}, y2_root})
                   + 49'sd1) >>> 1;

   assign s_c0 = sat_field({{(SAT_W-CAB_W){i12.cab0[CAB_W-1]}}, i12.cab0});
   assign s_c1 = sat_field({{(SAT_W-CAB_W){i12.cab1[CAB_W-1]}}, i12.cab1});
   assign s_c2 = sat_field({{(SAT_W-CAB_W){i12.cab2[CAB_W-1]}}, i12.cab2});
   assign s_c3 = sat_field({{(SAT_W-CAB_W){i12.cab3[CAB_W-1]}}, i12.cab3});
   assign s_x  = sat_field(sx_full);
   assign s_y  = sat_field(sy_full);

   logic signed [FIELD_W-1:0] c0_ff, c1_ff, c2_ff, c3_ff, sx_ff, sy_ff;
   logic                      unr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= v12;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         case (i12.kind)
            REQ_INVERSE: begin
               c0_ff  <= s_c0[FIELD_W-1:0];
               c1_ff  <= s_c1[FIELD_W-1:0];
               c2_ff  <= s_c2[FIELD_W-1:0];
               c3_ff  <= s_c3[FIELD_W-1:0];
               sx_ff  <= '0;
               sy_ff  <= '0;
               unr_ff <= s_c0[FIELD_W] | s_c1[FIELD_W] | s_c2[FIELD_W] | s_c3[FIELD_W];
            end
            REQ_FORWARD: begin
               c0_ff  <= '0;
               c1_ff  <= '0;
               c2_ff  <= '0;
               c3_ff  <= '0;
               sx_ff  <= s_x[FIELD_W-1:0];
               sy_ff  <= s_y[FIELD_W-1:0];
               unr_ff <= i12.neg | s_x[FIELD_W] | s_y[FIELD_W];
            end
            default: begin
               c0_ff  <= '0;
               c1_ff  <= '0;
               c2_ff  <= '0;
               c3_ff  <= '0;
               sx_ff  <= '0;
               sy_ff  <= '0;
               unr_ff <= 1'b0;
            end
         endcase
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_cable_top_left     = c0_ff;
   assign rsp_cable_top_right    = c1_ff;
   assign rsp_cable_bottom_right = c2_ff;
   assign rsp_cable_bottom_left  = c3_ff;
   assign rsp_solved_x           = sx_ff;
   assign rsp_solved_y           = sy_ff;
   assign rsp_unreachable        = unr_ff;

endmodule

// File: sv/fcpk_checker.sv
// Port-level checker for the kinematics block, bound to the top level.
module fcpk_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_stall,
   input logic                    req_type,
   input logic signed [21:0]      req_target_x,
   input logic signed [21:0]      req_target_y,
   input logic signed [21:0]      req_top_left_len,
   input logic signed [21:0]      req_top_right_len,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input logic signed [21:0]      rsp_cable_top_left,
   input logic signed [21:0]      rsp_cable_top_right,
   input logic signed [21:0]      rsp_cable_bottom_right,
   input logic signed [21:0]      rsp_cable_bottom_left,
   input logic signed [21:0]      rsp_solved_x,
   input logic signed [21:0]      rsp_solved_y,
   input logic                    rsp_unreachable,
   input logic                    csr_valid,
   input logic                    csr_ready,
   input fcpk_pkg::csr_index_type csr_index,
   input logic [19:0]             csr_data
);
   import fcpk_pkg::*;

   // held response word keeps its position, top-left cable and unreachable flag
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_solved_x)
         && $stable(rsp_solved_y) && $stable(rsp_cable_top_left)
         && $stable(rsp_unreachable))
      else $error("response changed while stalled");

   // a word is either inverse (no position) or forward (no cables)
   a_mode_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_solved_x == 22'sd0 && rsp_solved_y == 22'sd0)
         || (rsp_cable_top_left == 22'sd0 && rsp_cable_top_right == 22'sd0
             && rsp_cable_bottom_right == 22'sd0 && rsp_cable_bottom_left == 22'sd0))
      else $error("inverse and forward fields mixed");

   // reset empties the pipe and the input skid
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("pipe not empty after reset");

   // input skid drains as soon as the output side moves
   a_skid_drain: assert property (@(posedge clock) disable iff (reset)
      req_stall && !(rsp_valid && rsp_stall) |=> !req_stall)
      else $error("input stall held without output stall");

endmodule

bind four_cable_plotter_kinematics fcpk_checker u_fcpk_checker (.*);
